// ===== design/gcd_pkg.sv =====
// Package for the Euclidean GCD core: datapath widths and the request and
// response structs between the sequencer and the remainder unit.
// No dependencies.
package gcd_pkg;

	// Width of the external operand and result fields.
	localparam int DATA_W = 32;
	// Width of the internal datapath; operands are cut to this many bits.
	localparam int WIDTH = 32;
	// Step counter of the bit-serial remainder unit.
	localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Start request to the remainder unit: compute num % den, den nonzero.
	typedef struct packed {
		logic  start;
		word_t num;
		word_t den;
	} rem_req_t;

	// Response from the remainder unit: done pulses for one cycle with rem.
	typedef struct packed {
		logic  done;
		word_t rem;
	} rem_rsp_t;

endpackage

// ===== design/gcd_if.sv =====
// Valid/ready channel interfaces for the GCD core: operand pair in,
// divisor out. Depends on gcd_pkg.
interface gcd_req_if;
	import gcd_pkg::*;

	logic  valid;
	logic  ready;
	data_t operand_a;
	data_t operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface gcd_rsp_if;
	import gcd_pkg::*;

	logic  valid;
	logic  ready;
	data_t divisor;

	modport source (output valid, output divisor, input ready);
	modport sink (input valid, input divisor, output ready);
endinterface

// ===== design/gcd_rem_unit.sv =====
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on gcd_pkg.
module gcd_rem_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  gcd_pkg::rem_req_t req,
	output gcd_pkg::rem_rsp_t rsp
);
	import gcd_pkg::*;

	logic  busy_q;
	logic  done_q;
	cnt_t  cnt_q;
	word_t num_q;
	word_t den_q;
	word_t rem_q;

	logic [WIDTH:0] shifted;
	logic [WIDTH:0] diff;
	word_t          rem_next;

	// Bring down the next dividend bit and subtract the divisor if it fits.
	always_comb begin
		shifted  = {rem_q, num_q[WIDTH-1]};
		diff     = shifted - {1'b0, den_q};
		rem_next = diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== design/gcd_euclid_modulo_core.sv =====
// Top level of the Euclidean GCD core: sequencer that repeatedly replaces
// the larger operand by its remainder. Depends on gcd_pkg, gcd_if, gcd_rem_unit.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  operand_a[31:0], operand_b[31:0]
//   rsp      out  valid/ready  divisor[31:0]
//
// An item takes one remainder step per step of Euclid's algorithm (none when
// an operand is zero, at most 45 for 32-bit operands); the bit-serial
// remainder unit does each step, one dividend bit per cycle. req is ready
// only in idle; the result register lets a new transfer in while the result
// waits. arst_n clears control state; no clearing pass is needed.
module gcd_euclid_modulo_core (
	input  logic clk,
	input  logic arst_n,
	gcd_req_if.sink   req,
	gcd_rsp_if.source rsp
);
	import gcd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WAIT,
		ST_DONE
	} state_t;

	state_t   state_q;
	word_t    a_q;
	word_t    b_q;
	logic     a_gt_q;
	logic     out_vld_q;
	data_t    res_q;
	rem_req_t rem_req;
	rem_rsp_t rem_rsp;
	logic     both_nz;
	logic     a_gt;
	logic     out_free;

	assign both_nz  = (a_q != '0) && (b_q != '0);
	assign a_gt     = a_q > b_q;
	assign out_free = !out_vld_q || rsp.ready;

	always_comb begin
		rem_req.start = (state_q == ST_CHECK) && both_nz;
		rem_req.num   = a_gt ? a_q : b_q;
		rem_req.den   = a_gt ? b_q : a_q;
	end

	gcd_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= both_nz ? ST_WAIT : ST_DONE;
				end
				ST_WAIT: begin
					if (rem_rsp.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand and result registers carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			a_q <= WIDTH'(req.operand_a);
			b_q <= WIDTH'(req.operand_b);
		end else if (state_q == ST_CHECK) begin
			a_gt_q <= a_gt;
		end else if (state_q == ST_WAIT && rem_rsp.done) begin
			if (a_gt_q) begin
				a_q <= rem_rsp.rem;
			end else begin
				b_q <= rem_rsp.rem;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			res_q <= DATA_W'(a_q | b_q);
		end
	end

	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = out_vld_q;
	assign rsp.divisor = res_q;

endmodule
